### src/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg
// Types and constants shared by the UART frame receiver with link watch.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] END_BYTE   = 8'hF1;
    localparam logic [7:0] SUM_MASK   = 8'h7F;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    localparam logic [7:0] ADDR_RESET  = 8'h02;
    localparam logic [7:0] LIMIT_RESET = 8'd30;

    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W    = 24;
    localparam int LAST_W   = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEPT_ADDR   = 1'b0,
        CFG_SILENCE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } t_state;

endpackage

### src/ufr_frame_mem.sv
// ----------------------------------------------------------------------------
// ufr_frame_mem
// Frame store: one write port, one registered read port, per-entry valid bits
// so that never-written entries read as zero right after reset.
// ----------------------------------------------------------------------------
module ufr_frame_mem #(
    parameter int DEPTH = 9,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [7:0]       r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule

### src/uart_frame_receiver_link_watch.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_link_watch
// Collects UART bytes into a frame store, checks frames addressed to this
// node, and watches link silence with a tick counter.
// ----------------------------------------------------------------------------
// Result: the result beat is registered from the accepted input beat, except
//   for a matching end byte, which first walks the store in ST_READ and then
//   checks in ST_FINISH, one store read per cycle through the single read port.
// Throughput: one beat per cycle for plain items while no result beat is
//   stalled; the checksum walk blocks input until its result is loaded.
// Reset: synchronous, clears flags, position, silence count, store valid bits.
// ----------------------------------------------------------------------------
module uart_frame_receiver_link_watch #(
    parameter int FRAME_LEN = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ufr_pkg::BYTE_W-1:0]    i_s_axis_tdata,  // [7:0] rx_byte
    input  logic [ufr_pkg::KIND_W-1:0]    i_s_axis_tuser,  // [1:0] kind
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [0] frame_accepted, [1] frame_ready, [2] link_ok, [3] receiving,
    // [11:4] signal_byte, [19:12] pulse_byte, [23:20] write_position
    output logic [ufr_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [ufr_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ufr_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import ufr_pkg::*;

    localparam int PW = $clog2(FRAME_LEN);

    t_state        r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_ready, n_ready;
    logic          r_link, n_link;
    logic [7:0]    r_sil, n_sil;
    logic          r_start, n_start;
    logic [7:0]    r_b1, n_b1, r_b2, n_b2, r_b3, n_b3, r_b4, n_b4;
    logic [7:0]    r_addr, r_limit;
    logic [PW-1:0] r_idx, n_idx, r_last, n_last;
    logic          r_rd_vld, n_rd_vld;
    logic [7:0]    r_sum, n_sum;
    logic          r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    logic          mem_we;
    logic [PW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic          in_fire, load_out, acc;
    logic [7:0]    rx, b1_new, len;
    logic [LAST_W-1:0] last9;
    logic [PW+3:0] pos_ext;
    t_kind         kind;

    ufr_frame_mem #(
        .DEPTH (FRAME_LEN),
        .AW    (PW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (rx),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rx   = i_s_axis_tdata;
    assign kind = t_kind'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_ready  = r_ready;
        n_link   = r_link;
        n_sil    = r_sil;
        n_start  = r_start;
        n_b1     = r_b1;
        n_b2     = r_b2;
        n_b3     = r_b3;
        n_b4     = r_b4;
        n_idx    = r_idx;
        n_last   = r_last;
        n_rd_vld = r_rd_vld;
        n_sum    = r_sum;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_raddr = r_idx;
        load_out  = 1'b0;
        acc       = 1'b0;
        b1_new    = (r_pos == PW'(1)) ? rx : r_b1;
        len       = (r_pos == PW'(2)) ? rx : r_b2;
        last9     = LAST_W'(3) + {1'b0, len};

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (kind)
                        KIND_BYTE: begin
                            if (r_pos == '0) begin
                                load_out = 1'b1;
                                if (rx == START_BYTE) begin
                                    mem_we  = 1'b1;
                                    n_pos   = PW'(1);
                                    n_start = 1'b1;
                                end
                            end else begin
                                mem_we = 1'b1;
                                n_pos  = (int'(r_pos) == FRAME_LEN - 1) ? '0 : r_pos + PW'(1);
                                if (b1_new == r_addr && rx == END_BYTE
                                        && last9 < LAST_W'(FRAME_LEN)) begin
                                    n_last   = last9[PW-1:0];
                                    n_idx    = PW'(1);
                                    n_sum    = 8'h00;
                                    n_rd_vld = 1'b0;
                                    n_state  = ST_READ;
                                end else begin
                                    load_out = 1'b1;
                                end
                            end
                        end
                        KIND_TICK: begin
                            load_out = 1'b1;
                            n_sil = (r_sil == COUNT_MAX) ? r_sil : r_sil + 8'd1;
                            if (n_sil > r_limit) begin
                                n_link = 1'b0;
                            end
                        end
                        KIND_CLEAR: begin
                            load_out = 1'b1;
                            n_ready  = 1'b0;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    n_sum = r_sum + mem_rdata;
                end
                if (r_idx == r_last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            ST_FINISH: begin
                n_state  = ST_IDLE;
                load_out = 1'b1;
                if (((~r_sum) & SUM_MASK) == mem_rdata) begin
                    acc     = 1'b1;
                    n_sil   = 8'h00;
                    n_pos   = '0;
                    n_ready = 1'b1;
                    n_link  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // shadow copies of the header and payload bytes
        if (mem_we) begin
            if (int'(mem_waddr) == 1) n_b1 = rx;
            if (int'(mem_waddr) == 2) n_b2 = rx;
            if (int'(mem_waddr) == 3) n_b3 = rx;
            if (int'(mem_waddr) == 4) n_b4 = rx;
        end

        pos_ext     = {4'b0000, n_pos};
        n_out_data  = {pos_ext[3:0], n_b4, n_b3, n_start, n_link, n_ready, acc};
        n_out_valid = load_out || (r_out_valid && !i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_ready     <= 1'b0;
            r_link      <= 1'b0;
            r_sil       <= 8'h00;
            r_start     <= 1'b0;
            r_b1        <= 8'h00;
            r_b2        <= 8'h00;
            r_b3        <= 8'h00;
            r_b4        <= 8'h00;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= ADDR_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_ready     <= n_ready;
            r_link      <= n_link;
            r_sil       <= n_sil;
            r_start     <= n_start;
            r_b1        <= n_b1;
            r_b2        <= n_b2;
            r_b3        <= n_b3;
            r_b4        <= n_b4;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_ACCEPT_ADDR:   r_addr  <= i_cfg_wdata;
                    CFG_SILENCE_LIMIT: r_limit <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_last <= n_last;
        r_sum  <= n_sum;
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### src/ufr_checker.sv
// ----------------------------------------------------------------------------
// ufr_checker
// Port-level checks for the UART frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ufr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ufr_pkg::OUT_W-1:0]     o_m_axis_tdata
);
    import ufr_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_accept_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |->
            o_m_axis_tdata[1] && o_m_axis_tdata[2] && o_m_axis_tdata[23:20] == 4'd0)
        else $error("accepted frame without ready, link ok and cleared position");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |-> !o_m_axis_tvalid || i_m_axis_tready)
        else $error("input beat taken while result beat is blocked");

endmodule

bind uart_frame_receiver_link_watch ufr_checker u_ufr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### bench/tb_uart_frame_receiver_link_watch.sv
// ----------------------------------------------------------------------------
// tb_uart_frame_receiver_link_watch
// Self-checking bench: a table of directed beats, then random frames, ticks
// and noise under four register settings, each status beat checked field by
// field against the table's expected value or an in-bench model of the frame store and link watch.
// ----------------------------------------------------------------------------
module tb_uart_frame_receiver_link_watch;
    import ufr_pkg::*;

    localparam int FRAME_LEN     = 9;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 50;
    localparam int LONG_BURST    = 260;
    localparam int HOLD_CYCLES   = 400;
    localparam int WATCHDOG      = 5000;
    localparam int MAX_REPORTS   = 60;

    typedef struct packed {
        logic [3:0] wpos;
        logic [7:0] pulse_byte;
        logic [7:0] sig_byte;
        logic       recv;
        logic       link;
        logic       ready;
        logic       accepted;
    } t_link_status;

    typedef struct packed {
        t_kind        k;
        logic [7:0]   b;
        logic         typed;
        t_link_status want;
    } t_dir_row;

    localparam int DIR_N = 27;
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{k: KIND_NONE,  b: 8'hFF, typed: 1'b1, want: '0},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b1, want: '0},
        '{k: KIND_TICK,  b: 8'h00, typed: 1'b1, want: '0},
        '{k: KIND_CLEAR, b: 8'h00, typed: 1'b1, want: '0},
        '{k: KIND_BYTE,  b: 8'hF0, typed: 1'b1,
          want: '{wpos: 4'd1, recv: 1'b1, default: '0}},
        '{k: KIND_BYTE,  b: 8'h02, typed: 1'b1,
          want: '{wpos: 4'd2, recv: 1'b1, default: '0}},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b1,
          want: '{wpos: 4'd3, recv: 1'b1, default: '0}},
        '{k: KIND_BYTE,  b: 8'h7D, typed: 1'b1,
          want: '{wpos: 4'd4, sig_byte: 8'h7D, recv: 1'b1, default: '0}},
        '{k: KIND_BYTE,  b: 8'hF1, typed: 1'b1,
          want: '{wpos: 4'd0, pulse_byte: 8'hF1, sig_byte: 8'h7D, recv: 1'b1,
                  link: 1'b1, ready: 1'b1, accepted: 1'b1}},
        '{k: KIND_CLEAR, b: 8'h00, typed: 1'b1,
          want: '{wpos: 4'd0, pulse_byte: 8'hF1, sig_byte: 8'h7D, recv: 1'b1,
                  link: 1'b1, default: '0}},
        // length 6 puts the checksum index past the store
        '{k: KIND_BYTE,  b: 8'hF0, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h02, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h06, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'hF1, typed: 1'b0, want: '0},
        // fill to the end of the store, wrap, then an ignored byte
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'hFF, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h33, typed: 1'b0, want: '0},
        // bad checksum
        '{k: KIND_BYTE,  b: 8'hF0, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h02, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h01, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'hAA, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'h00, typed: 1'b0, want: '0},
        '{k: KIND_BYTE,  b: 8'hF1, typed: 1'b0, want: '0},
        '{k: KIND_TICK,  b: 8'h5A, typed: 1'b0, want: '0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [BYTE_W-1:0]    i_s_axis_tdata = '0;  // [7:0] rx_byte
    logic [KIND_W-1:0]    i_s_axis_tuser = '0;  // [1:0] kind
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [0] frame_accepted, [1] frame_ready, [2] link_ok, [3] receiving,
    // [11:4] signal_byte, [19:12] pulse_byte, [23:20] write_position
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    uart_frame_receiver_link_watch #(
        .FRAME_LEN(FRAME_LEN)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model state
    logic [7:0]  fs_bytes [FRAME_LEN];
    int unsigned fs_pos;
    logic        fs_ready;
    logic        fs_link;
    logic        fs_seen;
    logic [7:0]  fs_quiet;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_limit;

    t_link_status status_due [$];
    int           errors;
    int           beats_in;
    int           useful;
    int           frames_seen;
    int           stall_cycles;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           hold_left;
    bit           hold_go;

    function automatic logic checksum_matches();
        int unsigned last;
        int unsigned i;
        logic [7:0]  sum;
        last = 3 + fs_bytes[2];
        sum = '0;
        if (last >= FRAME_LEN) begin
            return 1'b0;
        end
        for (i = 1; i < last; i++) begin
            sum = sum + fs_bytes[i];
        end
        return ((~sum) & SUM_MASK) == fs_bytes[last];
    endfunction

    function automatic logic store_rx_byte(input logic [7:0] b);
        if (fs_pos >= FRAME_LEN) begin
            fs_pos = 0;
        end
        if (fs_pos == 0) begin
            if (b == START_BYTE) begin
                fs_bytes[0] = b;
                fs_pos = 1;
                fs_seen = 1'b1;
            end
            return 1'b0;
        end
        fs_bytes[fs_pos] = b;
        fs_pos = (fs_pos + 1) % FRAME_LEN;
        if (fs_bytes[1] != reg_addr || b != END_BYTE || !checksum_matches()) begin
            return 1'b0;
        end
        fs_quiet = '0;
        fs_pos = 0;
        fs_ready = 1'b1;
        fs_link = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_link_status predict_status(input t_kind k, input logic [7:0] b);
        t_link_status r;
        r = '0;
        case (k)
            KIND_BYTE: begin
                r.accepted = store_rx_byte(b);
            end
            KIND_TICK: begin
                if (fs_quiet < COUNT_MAX) begin
                    fs_quiet = fs_quiet + 8'd1;
                end
                if (fs_quiet > reg_limit) begin
                    fs_link = 1'b0;
                end
            end
            KIND_CLEAR: begin
                fs_ready = 1'b0;
            end
            default: begin
            end
        endcase
        r.ready = fs_ready;
        r.link = fs_link;
        r.recv = fs_seen;
        r.sig_byte = fs_bytes[3];
        r.pulse_byte = fs_bytes[4];
        r.wpos = 4'(fs_pos);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        if (errors < MAX_REPORTS) begin
            $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        end
        errors++;
    endtask

    task automatic offer_beat(input t_kind k, input logic [7:0] b,
                              input logic typed = 1'b0, input t_link_status given = '0);
        t_link_status want;
        if (k == KIND_TICK || k == KIND_CLEAR ||
            (k == KIND_BYTE && (fs_pos != 0 || b == START_BYTE))) begin
            useful++;
        end
        want = predict_status(k, b);
        status_due.push_back(typed ? given : want);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tuser <= k;
        do @(posedge i_clk); while (!o_s_axis_tready);
        beats_in++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACCEPT_ADDR) begin
            reg_addr = v;
        end else begin
            reg_limit = v;
        end
    endtask

    task automatic send_frame();
        logic [7:0] seq [$];
        logic [7:0] adr;
        logic [7:0] len;
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        int         cut;
        if ($urandom_range(99) < 80) begin
            // realign to the start of the store
            while (fs_pos != 0) begin
                b = 8'($urandom);
                offer_beat(KIND_BYTE, (b == END_BYTE) ? 8'h00 : b);
            end
        end
        adr = ($urandom_range(99) < 85) ? reg_addr : 8'($urandom);
        len = ($urandom_range(99) < 90) ? 8'($urandom_range(4)) : 8'($urandom_range(255, 5));
        sum = adr + len;
        seq.push_back(START_BYTE);
        seq.push_back(adr);
        seq.push_back(len);
        if (len <= 8'd4) begin
            for (i = 0; i < len; i++) begin
                b = 8'($urandom);
                sum = sum + b;
                seq.push_back(b);
            end
        end
        b = (~sum) & SUM_MASK;
        if ($urandom_range(99) < 10) begin
            b = b ^ (8'h01 << $urandom_range(7));
        end
        seq.push_back(b);
        seq.push_back(END_BYTE);
        cut = ($urandom_range(99) < 10) ? $urandom_range(5, 1) : seq.size();
        for (i = 0; i < cut && i < seq.size(); i++) begin
            if ($urandom_range(99) < 6) begin
                offer_beat(t_kind'($urandom_range(3, 1)), 8'($urandom));
            end
            offer_beat(KIND_BYTE, seq[i]);
        end
    endtask

    task automatic send_random_unit();
        int sel;
        sel = $urandom_range(99);
        if (sel < 62) begin
            send_frame();
        end else if (sel < 74) begin
            repeat ($urandom_range(40, 1)) offer_beat(KIND_TICK, 8'($urandom));
        end else if (sel < 82) begin
            offer_beat(KIND_CLEAR, 8'($urandom));
        end else if (sel < 88) begin
            offer_beat(KIND_NONE, 8'($urandom));
        end else begin
            offer_beat(KIND_BYTE, 8'($urandom));
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [7:0] adr,
                             input logic [7:0] lim, input bit long_ticks, input bit hold,
                             input bit pause);
        int start;
        bit burst_done;
        drain();
        write_reg(CFG_ACCEPT_ADDR, adr);
        write_reg(CFG_SILENCE_LIMIT, lim);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold) begin
            hold_go = 1'b1;
        end
        start = useful;
        burst_done = 1'b0;
        while (useful - start < PHASE_ITEMS) begin
            send_random_unit();
            if (long_ticks && !burst_done && useful - start >= PHASE_ITEMS / 2) begin
                // run the silence counter into saturation
                repeat (LONG_BURST) offer_beat(KIND_TICK, 8'($urandom));
                burst_done = 1'b1;
                if (pause) begin
                    drain();
                end
            end
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_link_status got;
        t_link_status want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_link_status'(o_m_axis_tdata);
            if (status_due.size() == 0) begin
                report_mismatch("status beat with nothing pending", got, '0);
            end else begin
                want = status_due.pop_front();
                if (got.accepted !== want.accepted)
                    report_mismatch("frame_accepted", got.accepted, want.accepted);
                if (got.ready !== want.ready)
                    report_mismatch("frame_ready", got.ready, want.ready);
                if (got.link !== want.link)
                    report_mismatch("link_ok", got.link, want.link);
                if (got.recv !== want.recv)
                    report_mismatch("receiving", got.recv, want.recv);
                if (got.sig_byte !== want.sig_byte)
                    report_mismatch("signal_byte", got.sig_byte, want.sig_byte);
                if (got.pulse_byte !== want.pulse_byte)
                    report_mismatch("pulse_byte", got.pulse_byte, want.pulse_byte);
                if (got.wpos !== want.wpos)
                    report_mismatch("write_position", got.wpos, want.wpos);
                if (got.accepted === 1'b1) begin
                    frames_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < FRAME_LEN; i++) begin
            fs_bytes[i] = '0;
        end
        fs_pos = 0;
        fs_ready = 1'b0;
        fs_link = 1'b0;
        fs_seen = 1'b0;
        fs_quiet = '0;
        reg_addr = ADDR_RESET;
        reg_limit = LIMIT_RESET;
        errors = 0;
        beats_in = 0;
        useful = 0;
        frames_seen = 0;
        stall_cycles = 0;
        hold_left = 0;
        hold_go = 1'b0;
        tx_idle_pct = 13;
        rx_idle_pct = 85;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++) begin
            offer_beat(DIR_ROWS[i].k, DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        run_phase(13, 85, 8'h5A, 8'd0,   1'b0, 1'b0, 1'b0);
        run_phase(85, 13, 8'h00, 8'd254, 1'b1, 1'b0, 1'b1);
        run_phase(0,  0,  8'hFF, 8'd255, 1'b1, 1'b1, 1'b0);
        run_phase(0,  0,  END_BYTE, 8'd7, 1'b0, 1'b0, 1'b0);
        drain();

        $display("covered %0d input beats: directed table plus four register settings", beats_in);
        $display("%0d frames accepted; addresses 5A/00/FF/F1, silence limits 0/254/255/7",
                 frames_seen);
        if (errors == 0 && status_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d status beats missing", errors, status_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
src/ufr_pkg.sv
src/ufr_frame_mem.sv
src/uart_frame_receiver_link_watch.sv
src/ufr_checker.sv
bench/tb_uart_frame_receiver_link_watch.sv
